// ===== rtl/cplm_pkg.sv =====
// Package for the complex pixel log magnitude core.
// Shared constants and the configuration register codes; no dependencies.
`default_nettype none
package cplm_pkg;

    // ln(2) in unsigned Q0.32, rounded
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Square root datapath: radicand (re^2+im^2) << 16, padded to an even width
    localparam int SUM_W   = 17;
    localparam int RAD_W   = 34;
    localparam int ROOT_W  = 17;
    localparam int REM_W   = 19;
    localparam int SQRT_STEPS = RAD_W / 2;

    // Mantissa in Q1.30 for the log squaring chain
    localparam int MANT_W  = 31;
    localparam int EXP_W   = 4;

    // Divider: eight quotient bits, remainder one bit wider than the divisor
    localparam int DIV_STEPS = 8;
    localparam int NORM_W  = 16;
    localparam int DREM_W  = 17;
    localparam int WIDTH_W = 13;
    localparam int CFG_W   = 16;

    // Configuration register indexes
    typedef enum logic {
        CFG_IMAGE_WIDTH = 1'b0,
        CFG_NORM_VALUE  = 1'b1
    } t_cfg_idx;

endpackage
`default_nettype wire

// ===== rtl/cplm_in_if.sv =====
// Input channel of the complex pixel log magnitude core: one pixel pair per request.
// Depends on nothing.
`default_nettype none
interface cplm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] real_part;
    logic [7:0] imag_part;

    modport source (output valid, output real_part, output imag_part, input ready);
    modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface
`default_nettype wire

// ===== rtl/cplm_out_if.sv =====
// Output channel of the complex pixel log magnitude core: one byte per request.
// Depends on nothing.
`default_nettype none
interface cplm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/cplm_sqrt_cell.sv =====
// One digit cell of the restoring integer square root chain.
// Depends on cplm_pkg.
`default_nettype none
module cplm_sqrt_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [cplm_pkg::RAD_W-1:0]    i_rad,
    input  wire logic [cplm_pkg::REM_W-1:0]    i_rem,
    input  wire logic [cplm_pkg::ROOT_W-1:0]   i_root,
    output logic                               o_valid,
    output logic [cplm_pkg::RAD_W-1:0]         o_rad,
    output logic [cplm_pkg::REM_W-1:0]         o_rem,
    output logic [cplm_pkg::ROOT_W-1:0]        o_root
);
    logic                            r_valid;
    logic [cplm_pkg::RAD_W-1:0]      r_rad, n_rad;
    logic [cplm_pkg::REM_W-1:0]      r_rem, n_rem;
    logic [cplm_pkg::ROOT_W-1:0]     r_root, n_root;
    logic [cplm_pkg::REM_W+1:0]      t, trial;
    logic                            ge;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
        t      = {i_rem, i_rad[cplm_pkg::RAD_W-1 -: 2]};
        trial  = {2'b00, i_root, 2'b01};
        ge     = (t >= trial);
        n_rem  = ge ? cplm_pkg::REM_W'(t - trial) : t[cplm_pkg::REM_W-1:0];
        n_root = {i_root[cplm_pkg::ROOT_W-2:0], ge};
        n_rad  = {i_rad[cplm_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

`ifndef NO_ASSERTIONS
    // Partial remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_rem} <= {2'b00, r_root, 1'b0}))
        else $error("sqrt remainder out of bound");
`endif
endmodule
`default_nettype wire

// ===== rtl/cplm_log_cell.sv =====
// One fraction bit cell of the log2 chain: square the mantissa and renormalise.
// Depends on cplm_pkg.
`default_nettype none
module cplm_log_cell #(
    parameter int FRAC_W = 13
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [cplm_pkg::MANT_W-1:0]   i_mant,
    input  wire logic [cplm_pkg::EXP_W-1:0]    i_exp,
    input  wire logic [FRAC_W-1:0]             i_frac,
    output logic                               o_valid,
    output logic [cplm_pkg::MANT_W-1:0]        o_mant,
    output logic [cplm_pkg::EXP_W-1:0]         o_exp,
    output logic [FRAC_W-1:0]                  o_frac
);
    logic                            r_valid;
    logic [cplm_pkg::MANT_W-1:0]     r_mant, n_mant;
    logic [cplm_pkg::EXP_W-1:0]      r_exp;
    logic [FRAC_W-1:0]               r_frac, n_frac;
    logic [2*cplm_pkg::MANT_W-1:0]   sq;
    logic [cplm_pkg::MANT_W:0]       t;

    // Square, drop the low fraction, halve when the square reaches two
    always_comb begin
        sq     = i_mant * i_mant;
        t      = sq[2*cplm_pkg::MANT_W-1 -: cplm_pkg::MANT_W+1];
        n_mant = t[cplm_pkg::MANT_W] ? t[cplm_pkg::MANT_W:1] : t[cplm_pkg::MANT_W-1:0];
        n_frac = {i_frac[FRAC_W-2:0], t[cplm_pkg::MANT_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mant <= n_mant;
            r_exp  <= i_exp;
            r_frac <= n_frac;
        end
    end

    assign o_valid = r_valid;
    assign o_mant  = r_mant;
    assign o_exp   = r_exp;
    assign o_frac  = r_frac;
endmodule
`default_nettype wire

// ===== rtl/cplm_div_cell.sv =====
// One quotient bit cell of the restoring divider by the normalisation value.
// Depends on cplm_pkg.
`default_nettype none
module cplm_div_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [cplm_pkg::NORM_W-1:0]   i_norm,
    input  wire logic [cplm_pkg::DREM_W-1:0]   i_rem,
    input  wire logic [7:0]                    i_lo,
    input  wire logic [7:0]                    i_quo,
    input  wire logic                          i_sat,
    output logic                               o_valid,
    output logic [cplm_pkg::DREM_W-1:0]        o_rem,
    output logic [7:0]                         o_lo,
    output logic [7:0]                         o_quo,
    output logic                               o_sat
);
    logic                            r_valid;
    logic [cplm_pkg::DREM_W-1:0]     r_rem, n_rem, t;
    logic [7:0]                      r_lo, r_quo;
    logic                            r_sat;
    logic                            ge;

    // Shift in the next dividend bit and subtract where it fits; a zero divisor
    // yields a zero quotient, so a zero log under a zero norm gives zero
    always_comb begin
        t     = {i_rem[cplm_pkg::DREM_W-2:0], i_lo[7]};
        ge    = (t >= {1'b0, i_norm}) && (i_norm != '0);
        n_rem = ge ? (t - {1'b0, i_norm}) : t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_lo  <= {i_lo[6:0], 1'b0};
            r_quo <= {i_quo[6:0], ge};
            r_sat <= i_sat;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_lo    = r_lo;
    assign o_quo   = r_quo;
    assign o_sat   = r_sat;
endmodule
`default_nettype wire

// ===== rtl/complex_pixel_log_magnitude_core.sv =====
// Complex pixel log magnitude core. Takes one pixel pair (real, imaginary byte) per
// request and returns floor(256 * ln(1+|z|) * image_width / norm_value), clamped to 0..255.
// One pixel is accepted every clock while the output is taken. The chain holds a sum stage,
// 17 square root cells, a normalise stage, LOG_FRAC_BITS squaring cells, two multiply
// stages, a divider setup stage, 8 divider cells and the output register. A stalled
// output holds the whole chain.
// Depends on cplm_pkg, cplm_in_if, cplm_out_if and the three cell modules.
`default_nettype none
module complex_pixel_log_magnitude_core #(
    parameter int LOG_FRAC_BITS = 13
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [cplm_pkg::CFG_W-1:0]    i_cfg_data,
    cplm_in_if.sink                            i_pix,
    cplm_out_if.source                         o_pix
);
    localparam int F    = LOG_FRAC_BITS;
    localparam int L2_W = cplm_pkg::EXP_W + F;
    localparam int P_W  = L2_W + cplm_pkg::WIDTH_W;
    localparam int D_W  = P_W - (F - 8);
    localparam int CMP_W = 48;
    localparam int NS   = cplm_pkg::SQRT_STEPS;
    localparam int ND   = cplm_pkg::DIV_STEPS;

    logic                             en;
    logic [cplm_pkg::WIDTH_W-1:0]     r_width;
    logic [cplm_pkg::NORM_W-1:0]      r_norm;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= cplm_pkg::WIDTH_W'(256);
            r_norm  <= cplm_pkg::NORM_W'(1024);
        end else if (i_cfg_we) begin
            case (cplm_pkg::t_cfg_idx'(i_cfg_idx))
                cplm_pkg::CFG_IMAGE_WIDTH: r_width <= i_cfg_data[cplm_pkg::WIDTH_W-1:0];
                cplm_pkg::CFG_NORM_VALUE:  r_norm  <= i_cfg_data;
                default: r_width <= r_width;
            endcase
        end
    end

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_pix;
    assign en          = !r_out_valid || o_pix.ready;
    assign i_pix.ready = en;
    assign o_pix.valid = r_out_valid;
    assign o_pix.pixel_out = r_out_pix;

    // Sum of squares
    logic                           r_s_valid;
    logic [cplm_pkg::SUM_W-1:0]     r_sum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (en) begin
            r_s_valid <= i_pix.valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum <= cplm_pkg::SUM_W'({8'h00, i_pix.real_part} * {8'h00, i_pix.real_part})
                   + cplm_pkg::SUM_W'({8'h00, i_pix.imag_part} * {8'h00, i_pix.imag_part});
        end
    end

    // Square root chain
    logic [NS:0]                    sq_valid;
    logic [cplm_pkg::RAD_W-1:0]     sq_rad  [NS+1];
    logic [cplm_pkg::REM_W-1:0]     sq_rem  [NS+1];
    logic [cplm_pkg::ROOT_W-1:0]    sq_root [NS+1];
    assign sq_valid[0] = r_s_valid;
    assign sq_rad[0]   = {1'b0, r_sum, 16'h0000};
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        cplm_sqrt_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(sq_valid[g]), .i_rad(sq_rad[g]), .i_rem(sq_rem[g]),
            .i_root(sq_root[g]),
            .o_valid(sq_valid[g+1]), .o_rad(sq_rad[g+1]), .o_rem(sq_rem[g+1]),
            .o_root(sq_root[g+1])
        );
    end

    // Normalise 1+magnitude: leading one position and mantissa in Q1.30
    logic [cplm_pkg::ROOT_W-1:0]    x;
    logic [cplm_pkg::EXP_W-1:0]     n_exp;
    logic [cplm_pkg::MANT_W-1:0]    n_mant;
    logic                           r_n_valid;
    logic [cplm_pkg::EXP_W-1:0]     r_n_exp;
    logic [cplm_pkg::MANT_W-1:0]    r_n_mant;
    always_comb begin
        x     = sq_root[NS] + cplm_pkg::ROOT_W'(256);
        n_exp = '0;
        for (int k = 9; k < cplm_pkg::ROOT_W; k++) begin
            if (x[k]) begin
                n_exp = cplm_pkg::EXP_W'(k - 8);
            end
        end
        n_mant = cplm_pkg::MANT_W'({14'h0000, x} << (5'd22 - 5'(n_exp)));
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (en) begin
            r_n_valid <= sq_valid[NS];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_exp  <= n_exp;
            r_n_mant <= n_mant;
        end
    end

    // Log2 squaring chain
    logic [F:0]                     lg_valid;
    logic [cplm_pkg::MANT_W-1:0]    lg_mant [F+1];
    logic [cplm_pkg::EXP_W-1:0]     lg_exp  [F+1];
    logic [F-1:0]                   lg_frac [F+1];
    assign lg_valid[0] = r_n_valid;
    assign lg_mant[0]  = r_n_mant;
    assign lg_exp[0]   = r_n_exp;
    assign lg_frac[0]  = '0;
    for (genvar g = 0; g < F; g++) begin : g_log
        cplm_log_cell #(.FRAC_W(F)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(lg_valid[g]), .i_mant(lg_mant[g]), .i_exp(lg_exp[g]),
            .i_frac(lg_frac[g]),
            .o_valid(lg_valid[g+1]), .o_mant(lg_mant[g+1]), .o_exp(lg_exp[g+1]),
            .o_frac(lg_frac[g+1])
        );
    end

    // Convert to natural log, then apply the width gain
    logic [L2_W+31:0]  ln_prod;
    logic              r_ln_valid, r_p_valid;
    logic [L2_W-1:0]   r_ln;
    logic [P_W-1:0]    r_prod;
    assign ln_prod = {lg_exp[F], lg_frac[F]} * cplm_pkg::LN2_Q32;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ln_valid <= 1'b0;
            r_p_valid  <= 1'b0;
        end else if (en) begin
            r_ln_valid <= lg_valid[F];
            r_p_valid  <= r_ln_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ln   <= ln_prod[L2_W+31:32];
            r_prod <= r_ln * r_width;
        end
    end

    // Divider setup: saturation test and initial remainder
    logic [D_W-1:0]                 dvd;
    logic                           n_sat;
    logic                           r_d_valid, r_d_sat;
    logic [cplm_pkg::DREM_W-1:0]    r_d_rem;
    logic [7:0]                     r_d_lo;
    always_comb begin
        dvd = r_prod[P_W-1:F-8];
        if (r_norm == '0) begin
            n_sat = (r_prod != '0);
        end else begin
            n_sat = (CMP_W'(dvd) >= CMP_W'({r_norm, 8'h00}));
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= r_p_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_sat <= n_sat;
            r_d_rem <= cplm_pkg::DREM_W'(dvd >> 8);
            r_d_lo  <= dvd[7:0];
        end
    end

    // Divider chain
    logic [ND:0]                    dv_valid, dv_sat;
    logic [cplm_pkg::DREM_W-1:0]    dv_rem [ND+1];
    logic [7:0]                     dv_lo  [ND+1];
    logic [7:0]                     dv_quo [ND+1];
    assign dv_valid[0] = r_d_valid;
    assign dv_sat[0]   = r_d_sat;
    assign dv_rem[0]   = r_d_rem;
    assign dv_lo[0]    = r_d_lo;
    assign dv_quo[0]   = '0;
    for (genvar g = 0; g < ND; g++) begin : g_div
        cplm_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(dv_valid[g]), .i_norm(r_norm), .i_rem(dv_rem[g]),
            .i_lo(dv_lo[g]), .i_quo(dv_quo[g]), .i_sat(dv_sat[g]),
            .o_valid(dv_valid[g+1]), .o_rem(dv_rem[g+1]), .o_lo(dv_lo[g+1]),
            .o_quo(dv_quo[g+1]), .o_sat(dv_sat[g+1])
        );
    end

    // Clamp and hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid[ND];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_pix <= dv_sat[ND] ? 8'hFF : dv_quo[ND];
        end
    end

`ifndef NO_ASSERTIONS
    // No result straight out of reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix.valid)
        else $error("output valid after reset");
    // A stalled output blocks new input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_pix.ready) |-> !i_pix.ready)
        else $error("input taken while output stalled");
    // A stall freezes the chain occupancy
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(sq_valid) && $stable(dv_valid))
        else $error("chain moved during stall");
`endif
endmodule
`default_nettype wire
